// ----- rtl/stc_pkg.sv -----
`timescale 1ns / 1ps

package stc_pkg;

  localparam int unsigned CHAR_W = 8;

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_NL    = 8'h0A;
  localparam char_t CH_FF    = 8'h0C;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_SPACE = 8'h20;

endpackage

// ----- rtl/stc_in_if.sv -----
`timescale 1ns / 1ps

interface stc_in_if;
  logic            valid;
  logic            ready;
  stc_pkg::char_t  in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

// ----- rtl/stc_out_if.sv -----
`timescale 1ns / 1ps

interface stc_out_if;
  logic            valid;
  logic            ready;
  stc_pkg::char_t  out_char;
  logic            last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

// ----- rtl/stc_cfg.sv -----
`timescale 1ns / 1ps

module stc_cfg #(
  parameter int unsigned TAB_STOP = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  stc_pkg::char_t                cfg_wdata,
  output logic [$clog2(TAB_STOP)-1:0]   start_phase,
  output logic                          reload
);
  import stc_pkg::*;

  localparam int unsigned PW = $clog2(TAB_STOP);

  logic [PW-1:0] start_phase_r;
  logic          reload_r;
  logic [15:0]   rem;

  // Restoring reduction of the written column modulo the tab stop
  always_comb begin
    rem = {8'd0, cfg_wdata};
    for (int k = 7; k >= 0; k--) begin
      if (rem >= (16'(TAB_STOP) << k)) begin
        rem = rem - (16'(TAB_STOP) << k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_phase_r <= '0;
      reload_r      <= 1'b0;
    end else begin
      reload_r <= cfg_we;
      if (cfg_we) begin
        start_phase_r <= rem[PW-1:0];
      end
    end
  end

  assign start_phase = start_phase_r;
  assign reload      = reload_r;

endmodule

// ----- rtl/stc_core.sv -----
`timescale 1ns / 1ps

module stc_core #(
  parameter int unsigned TAB_STOP = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(TAB_STOP)-1:0]   start_phase,
  input  logic                          reload,
  stc_in_if.sink                        in_ch,
  stc_out_if.source                     out_ch
);
  import stc_pkg::*;

  localparam int unsigned PW = $clog2(TAB_STOP);
  localparam logic [PW-1:0] LAST_PHASE = PW'(TAB_STOP - 1);

  logic [PW-1:0] phase_r, phase_nxt;
  logic [PW-1:0] pending_r, pending_nxt;

  logic          work_valid_r, work_valid_nxt;
  char_t         work_char_r, work_char_nxt;
  logic [PW-1:0] work_spaces_r, work_spaces_nxt;

  logic          out_valid_r, out_valid_nxt;
  char_t         out_char_r, out_char_nxt;
  logic          out_last_r, out_last_nxt;

  logic          out_adv;
  logic          in_fire;
  logic [PW-1:0] phase_step;
  char_t         c;

  assign out_adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !reload &&
                       (!work_valid_r || (out_adv && (work_spaces_r == '0)));
  assign in_fire = in_ch.valid && in_ch.ready;
  assign c = in_ch.in_char;

  always_comb begin
    phase_step = (phase_r == LAST_PHASE) ? '0 : phase_r + PW'(1);
    if (c == CH_NL || c == CH_CR || c == CH_FF) begin
      phase_step = '0;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    pending_nxt     = pending_r;
    work_valid_nxt  = work_valid_r;
    work_char_nxt   = work_char_r;
    work_spaces_nxt = work_spaces_r;
    out_valid_nxt   = out_valid_r;
    out_char_nxt    = out_char_r;
    out_last_nxt    = out_last_r;

    // Drain the work slot: held spaces first, then the byte itself
    if (out_adv) begin
      out_valid_nxt = work_valid_r;
      if (work_valid_r) begin
        if (work_spaces_r != '0) begin
          out_char_nxt    = CH_SPACE;
          out_last_nxt    = 1'b0;
          work_spaces_nxt = work_spaces_r - PW'(1);
        end else begin
          out_char_nxt   = work_char_r;
          out_last_nxt   = 1'b1;
          work_valid_nxt = 1'b0;
        end
      end
    end

    if (reload) begin
      phase_nxt   = start_phase;
      pending_nxt = '0;
    end else if (in_fire) begin
      if (c == CH_NUL) begin
        // End of text: drop held spaces, re-arm the column
        phase_nxt       = start_phase;
        pending_nxt     = '0;
        work_valid_nxt  = 1'b1;
        work_char_nxt   = CH_NUL;
        work_spaces_nxt = '0;
      end else begin
        phase_nxt = phase_step;
        if (c == CH_SPACE) begin
          if (phase_step == '0) begin
            pending_nxt     = '0;
            work_valid_nxt  = 1'b1;
            work_char_nxt   = CH_TAB;
            work_spaces_nxt = '0;
          end else if (pending_r < LAST_PHASE) begin
            pending_nxt = pending_r + PW'(1);
          end
        end else begin
          pending_nxt     = '0;
          work_valid_nxt  = 1'b1;
          work_char_nxt   = c;
          work_spaces_nxt = pending_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      pending_r    <= '0;
      work_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      pending_r    <= pending_nxt;
      work_valid_r <= work_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_char_r   <= work_char_nxt;
    work_spaces_r <= work_spaces_nxt;
    out_char_r    <= out_char_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_char    = out_char_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

// ----- rtl/space_to_tab_compressor.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Transfer when   Payload
// in_ch     in   valid & ready   in_char[7:0]
// out_ch    out  valid & ready   out_char[7:0], last_of_run
// cfg       in   cfg_we high     cfg_wdata[7:0] (start column)
//
// One input byte per cycle while out_ch is not stalled; a byte with N held
// spaces stays in the work slot for N+1 output transfers, and the input
// stalls until its spaces are out. Input passes the work slot, then the
// output register. A start column write blocks input while the column
// reloads. rst_n is synchronous, active low; the column resets to zero.

module space_to_tab_compressor #(
  parameter int unsigned TAB_STOP = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  stc_in_if.sink          in_ch,
  stc_out_if.source       out_ch,
  input  logic            cfg_we,
  input  stc_pkg::char_t  cfg_wdata
);
  import stc_pkg::*;

  localparam int unsigned PW = $clog2(TAB_STOP);

  logic [PW-1:0] start_phase;
  logic          reload;

  stc_cfg #(.TAB_STOP(TAB_STOP)) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .start_phase (start_phase),
    .reload      (reload)
  );

  stc_core #(.TAB_STOP(TAB_STOP)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_phase (start_phase),
    .reload      (reload),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

endmodule

// ----- verif/tb_space_to_tab_compressor.sv -----
`timescale 1ns / 1ps

module tb_space_to_tab_compressor;
  import stc_pkg::*;

  localparam int unsigned TAB_STOP    = 8;
  localparam int          PHASE_ITEMS = 52;
  localparam int          SETTLE_CYC  = 6;
  localparam int          IDLE_LIMIT  = 1000;

  typedef struct packed {
    char_t ch;
    logic  last;
  } result_t;

  typedef struct {
    char_t c;
    bit    typed;
    int    n;
    char_t ch;
    logic  last;
  } stim_row_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_we = 1'b0;
  char_t cfg_wdata = '0;

  stc_in_if  in_ch ();
  stc_out_if out_ch ();

  space_to_tab_compressor #(.TAB_STOP(TAB_STOP)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // compressor state tracked on the testbench side
  char_t       start_col;
  int unsigned model_col;
  int unsigned model_held;

  result_t expected_chars[$];
  int      errors;
  int      idle_cycles;
  bit      no_idle;

  // directed text; typed rows carry their single result (or none)
  stim_row_t directed_rows [27] = '{
    '{8'h41,    1'b1, 1, 8'h41,    1'b1},
    '{CH_SPACE, 1'b1, 0, CH_NUL,   1'b0},
    '{CH_SPACE, 1'b1, 0, CH_NUL,   1'b0},
    '{8'h42,    1'b0, 0, CH_NUL,   1'b0},
    '{CH_SPACE, 1'b1, 0, CH_NUL,   1'b0},
    '{CH_SPACE, 1'b1, 0, CH_NUL,   1'b0},
    '{CH_SPACE, 1'b1, 0, CH_NUL,   1'b0},
    '{CH_SPACE, 1'b1, 1, CH_TAB,   1'b1},
    '{CH_TAB,   1'b1, 1, CH_TAB,   1'b1},
    '{CH_NL,    1'b1, 1, CH_NL,    1'b1},
    '{CH_SPACE, 1'b1, 0, CH_NUL,   1'b0},
    '{CH_CR,    1'b0, 0, CH_NUL,   1'b0},
    '{CH_FF,    1'b1, 1, CH_FF,    1'b1},
    '{CH_SPACE, 1'b1, 0, CH_NUL,   1'b0},
    '{CH_SPACE, 1'b1, 0, CH_NUL,   1'b0},
    '{CH_SPACE, 1'b1, 0, CH_NUL,   1'b0},
    '{CH_SPACE, 1'b1, 0, CH_NUL,   1'b0},
    '{CH_SPACE, 1'b1, 0, CH_NUL,   1'b0},
    '{CH_SPACE, 1'b1, 0, CH_NUL,   1'b0},
    '{CH_SPACE, 1'b1, 0, CH_NUL,   1'b0},
    '{8'hFF,    1'b0, 0, CH_NUL,   1'b0},
    '{CH_SPACE, 1'b1, 0, CH_NUL,   1'b0},
    '{CH_NUL,   1'b1, 1, CH_NUL,   1'b1},
    '{8'h80,    1'b1, 1, 8'h80,    1'b1},
    '{CH_SPACE, 1'b1, 0, CH_NUL,   1'b0},
    '{CH_NUL,   1'b1, 1, CH_NUL,   1'b1},
    '{8'h01,    1'b1, 1, 8'h01,    1'b1}
  };

  function automatic void compress_byte(input char_t c, output result_t res[$]);
    res = {};
    if (c == CH_NUL) begin
      // end of text: drop held spaces, re-arm at the start column
      res.push_back('{CH_NUL, 1'b1});
      model_col  = start_col % TAB_STOP;
      model_held = 0;
      return;
    end
    model_col = (model_col + 1) % TAB_STOP;
    if (c == CH_NL || c == CH_CR || c == CH_FF)
      model_col = 0;
    if (c == CH_SPACE) begin
      if (model_col == 0) begin
        model_held = 0;
        res.push_back('{CH_TAB, 1'b1});
      end else if (model_held < TAB_STOP - 1) begin
        model_held++;
      end
      return;
    end
    repeat (model_held) res.push_back('{CH_SPACE, 1'b0});
    model_held = 0;
    res.push_back('{c, 1'b1});
  endfunction

  task automatic send_byte(input char_t c, input bit typed, input int n,
                           input char_t tch, input logic tlast);
    result_t res[$];
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.in_char = c;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    compress_byte(c, res);
    if (typed) begin
      if (n == 1) expected_chars.push_back('{tch, tlast});
    end else begin
      foreach (res[i]) expected_chars.push_back(res[i]);
    end
  endtask

  // hold off until the block has drained, then let it settle
  task automatic drain_outputs();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_start_col(input char_t v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    start_col  = v;
    model_col  = v % TAB_STOP;
    model_held = 0;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_text_phase();
    int    count;
    int    r;
    int    run_len;
    char_t c;
    count = 0;
    while (count < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        run_len = $urandom_range(1, 12);
        repeat (run_len) send_byte(CH_SPACE, 1'b0, 0, CH_NUL, 1'b0);
        count += run_len;
      end else begin
        if (r < 68) begin
          c = char_t'($urandom_range(8'h61, 8'h7A));
        end else if (r < 80) begin
          case ($urandom_range(0, 3))
            0: c = CH_NL;
            1: c = CH_CR;
            2: c = CH_FF;
            default: c = CH_TAB;
          endcase
        end else if (r < 85) begin
          c = CH_NUL;
        end else begin
          c = char_t'($urandom_range(0, 255));
        end
        send_byte(c, 1'b0, 0, CH_NUL, 1'b0);
        count++;
      end
    end
  endtask

  // result side: random ready bursts, always ready once idling is off
  int stall_left;
  int run_left;

  always @(negedge clk) begin
    if (no_idle) begin
      out_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (run_left > 0) begin
      out_ch.ready = 1'b1;
      run_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ch.ready = 1'b0;
      stall_left   = $urandom_range(1, 18) - 1;
    end else begin
      out_ch.ready = 1'b1;
      run_left     = $urandom_range(1, 30);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected transfer out_char %h last_of_run %b", $time,
                 out_ch.out_char, out_ch.last_of_run);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (out_ch.out_char !== want.ch) begin
          $display("%0t: out_char expected %h actual %h", $time, want.ch,
                   out_ch.out_char);
          errors++;
        end
        if (out_ch.last_of_run !== want.last) begin
          $display("%0t: last_of_run expected %b actual %b", $time, want.last,
                   out_ch.last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_chars.size());
      $display("tb_space_to_tab_compressor: FAIL");
      $finish;
    end
  end

  initial begin
    char_t phase_cols [6];
    errors        = 0;
    idle_cycles   = 0;
    no_idle       = 1'b0;
    stall_left    = 0;
    run_left      = 0;
    in_ch.valid   = 1'b0;
    in_ch.in_char = '0;
    out_ch.ready  = 1'b0;
    start_col     = '0;
    model_col     = 0;
    model_held    = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].n,
                directed_rows[i].ch, directed_rows[i].last);

    phase_cols = '{8'd255, 8'd7, 8'd8, char_t'($urandom_range(0, 255)), 8'd0,
                   char_t'($urandom_range(0, 255))};
    foreach (phase_cols[p]) begin
      drain_outputs();
      write_start_col(phase_cols[p]);
      if (p == 5) no_idle = 1'b1;
      run_text_phase();
    end

    drain_outputs();
    if (expected_chars.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_chars.size());
      errors++;
    end
    if (errors == 0)
      $display("tb_space_to_tab_compressor: PASS");
    else
      $display("tb_space_to_tab_compressor: FAIL");
    $finish;
  end

endmodule
